// File: rtl/ght_pkg.sv
`default_nettype none

package ght_pkg;

   localparam int OP_W        = 2;
   localparam int OBJ_PORT_W  = 48;
   localparam int TAG_W       = 16;
   localparam int IDX_PORT_W  = 12;
   localparam int HGEN_W      = 32;
   localparam int COUNT_W     = 32;
   localparam int LIVE_PORT_W = 12;

   // Wide intermediates used to widen or narrow fields whose stored width is a parameter.
   localparam int WIDE_W      = 64;
   localparam int IDX_WIDE_W  = 32;

   typedef enum logic [OP_W-1:0] {
      OP_REGISTER = 2'd0,
      OP_PIN      = 2'd1,
      OP_RELEASE  = 2'd2
   } op_type;

endpackage

`default_nettype wire

// File: rtl/ght_req_if.sv
`default_nettype none

interface ght_req_if import ght_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       operation;
   logic [OBJ_PORT_W-1:0] object_ref;
   logic [TAG_W-1:0]      free_tag;
   logic [IDX_PORT_W-1:0] slot_index;
   logic [HGEN_W-1:0]     handle_generation;

   modport source (
      output valid, operation, object_ref, free_tag, slot_index, handle_generation,
      input  ready
   );

   modport sink (
      input  valid, operation, object_ref, free_tag, slot_index, handle_generation,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/ght_rsp_if.sv
`default_nettype none

interface ght_rsp_if import ght_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   ok;
   logic [IDX_PORT_W-1:0]  new_index;
   logic [HGEN_W-1:0]      new_generation;
   logic [OBJ_PORT_W-1:0]  object_out;
   logic                   reclaimed;
   logic                   run_free;
   logic [TAG_W-1:0]       free_tag_out;
   logic [LIVE_PORT_W-1:0] live_count;

   modport source (
      output valid, ok, new_index, new_generation, object_out, reclaimed, run_free,
             free_tag_out, live_count,
      input  ready
   );

   modport sink (
      input  valid, ok, new_index, new_generation, object_out, reclaimed, run_free,
             free_tag_out, live_count,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/generational_handle_table.sv
// Channel    Port      Direction  Transaction
// request    req_chan  in         operation, object_ref, free_tag, slot_index,
//                                 handle_generation
// response   rsp_chan  out        ok, new_index, new_generation, object_out, reclaimed,
//                                 run_free, free_tag_out, live_count
//
// Each request is read from the slot memories when accepted in ST_IDLE, then
// updated and written back in ST_EXEC; req_chan.ready is high only in ST_IDLE.
// After reset a clearing pass writes zero generation and count to every slot
// (4096 by default), with req_chan.ready low throughout.
// A stalled response holds the update until the output register is free.
`default_nettype none

module generational_handle_table import ght_pkg::*; #(
   parameter int SLOTS       = 4096,
   parameter int GEN_BITS    = 32,
   parameter int OBJECT_BITS = 48
) (
   input  logic       clock,
   input  logic       reset,
   ght_req_if.sink    req_chan,
   ght_rsp_if.source  rsp_chan
);

   localparam int AW = $clog2(SLOTS);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type              state_ff, state_in;
   logic [AW-1:0]          clear_addr_ff, clear_addr_in;
   logic [AW-1:0]          head_ff, head_in;
   logic [AW-1:0]          fresh_ff, fresh_in;
   logic [AW-1:0]          live_ff, live_in;

   // Captured request.
   op_type                 op_ff, op_in;
   logic [OBJECT_BITS-1:0] obj_ff, obj_in;
   logic [TAG_W-1:0]       tag_ff, tag_in;
   logic [HGEN_W-1:0]      hgen_ff, hgen_in;
   logic                   in_range_ff, in_range_in;
   logic                   got_ff, got_in;
   logic                   from_head_ff, from_head_in;
   logic [AW-1:0]          addr_ff, addr_in;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   ok_ff, ok_in;
   logic [IDX_PORT_W-1:0]  new_index_ff, new_index_in;
   logic [HGEN_W-1:0]      new_gen_ff, new_gen_in;
   logic [OBJ_PORT_W-1:0]  obj_out_ff, obj_out_in;
   logic                   reclaimed_ff, reclaimed_in;
   logic                   run_free_ff, run_free_in;
   logic [TAG_W-1:0]       tag_out_ff, tag_out_in;
   logic [LIVE_PORT_W-1:0] live_out_ff, live_out_in;

   // Memory port signals.
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic                   wr_meta_en, wr_body_en;
   logic [AW-1:0]          wr_addr;
   logic [GEN_BITS-1:0]    wr_gen;
   logic [COUNT_W-1:0]     wr_count;
   logic [OBJECT_BITS-1:0] wr_obj;
   logic [TAG_W-1:0]       wr_tag;
   logic [AW-1:0]          wr_link;
   logic [GEN_BITS-1:0]    rd_gen;
   logic [COUNT_W-1:0]     rd_count;
   logic [OBJECT_BITS-1:0] rd_obj;
   logic [TAG_W-1:0]       rd_tag;
   logic [AW-1:0]          rd_link;

   logic                   req_fire;
   logic                   out_free;
   logic [IDX_WIDE_W-1:0]  idx_wide;
   logic [WIDE_W-1:0]      obj_req_wide;
   logic [WIDE_W-1:0]      obj_rd_wide;
   logic [IDX_WIDE_W-1:0]  addr_wide;
   logic [IDX_WIDE_W-1:0]  live_wide;
   logic                   live_slot;

   ght_slot_mem #(
      .DEPTH (SLOTS),
      .AW    (AW),
      .GW    (GEN_BITS),
      .OW    (OBJECT_BITS)
   ) u_mem (
      .clock      (clock),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .wr_meta_en (wr_meta_en),
      .wr_body_en (wr_body_en),
      .wr_addr    (wr_addr),
      .wr_gen     (wr_gen),
      .wr_count   (wr_count),
      .wr_obj     (wr_obj),
      .wr_tag     (wr_tag),
      .wr_link    (wr_link),
      .rd_gen     (rd_gen),
      .rd_count   (rd_count),
      .rd_obj     (rd_obj),
      .rd_tag     (rd_tag),
      .rd_link    (rd_link)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign idx_wide     = IDX_WIDE_W'(req_chan.slot_index);
   assign obj_req_wide = WIDE_W'(req_chan.object_ref);
   assign obj_rd_wide  = WIDE_W'(rd_obj);
   assign addr_wide    = IDX_WIDE_W'(addr_ff);
   assign live_wide    = IDX_WIDE_W'(live_in);

   assign live_slot = in_range_ff && (HGEN_W'(rd_gen) == hgen_ff) && (rd_count != '0);

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      head_in       = head_ff;
      fresh_in      = fresh_ff;
      live_in       = live_ff;

      op_in        = op_ff;
      obj_in       = obj_ff;
      tag_in       = tag_ff;
      hgen_in      = hgen_ff;
      in_range_in  = in_range_ff;
      got_in       = got_ff;
      from_head_in = from_head_ff;
      addr_in      = addr_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      ok_in        = ok_ff;
      new_index_in = new_index_ff;
      new_gen_in   = new_gen_ff;
      obj_out_in   = obj_out_ff;
      reclaimed_in = reclaimed_ff;
      run_free_in  = run_free_ff;
      tag_out_in   = tag_out_ff;
      live_out_in  = live_out_ff;

      rd_en      = 1'b0;
      rd_addr    = (head_ff != '0) ? head_ff : fresh_ff;
      wr_meta_en = 1'b0;
      wr_body_en = 1'b0;
      wr_addr    = addr_ff;
      wr_gen     = rd_gen;
      wr_count   = rd_count;
      wr_obj     = obj_ff;
      wr_tag     = tag_ff;
      wr_link    = rd_link;

      case (state_ff)
         ST_CLEAR: begin
            wr_meta_en    = 1'b1;
            wr_addr       = clear_addr_ff;
            wr_gen        = '0;
            wr_count      = '0;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == AW'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (op_type'(req_chan.operation) != OP_REGISTER) begin
               rd_addr = idx_wide[AW-1:0];
            end
            if (req_fire) begin
               rd_en        = 1'b1;
               op_in        = op_type'(req_chan.operation);
               obj_in       = obj_req_wide[OBJECT_BITS-1:0];
               tag_in       = req_chan.free_tag;
               hgen_in      = req_chan.handle_generation;
               in_range_in  = idx_wide < IDX_WIDE_W'(SLOTS);
               from_head_in = (head_ff != '0);
               got_in       = (obj_req_wide[OBJECT_BITS-1:0] != '0) &&
                              ((head_ff != '0) || (fresh_ff != '0));
               addr_in      = rd_addr;
               state_in     = ST_EXEC;
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               ok_in        = 1'b0;
               new_index_in = '0;
               new_gen_in   = '0;
               obj_out_in   = '0;
               reclaimed_in = 1'b0;
               run_free_in  = 1'b0;
               tag_out_in   = '0;

               case (op_ff)
                  OP_REGISTER: begin
                     if (got_ff) begin
                        wr_meta_en = 1'b1;
                        wr_body_en = 1'b1;
                        wr_count   = COUNT_W'(1);
                        if (from_head_ff) begin
                           head_in = rd_link;
                        end else begin
                           fresh_in = fresh_ff - 1'b1;
                        end
                        live_in      = live_ff + 1'b1;
                        ok_in        = 1'b1;
                        new_index_in = addr_wide[IDX_PORT_W-1:0];
                        new_gen_in   = HGEN_W'(rd_gen);
                     end
                  end

                  OP_PIN: begin
                     if (live_slot && (rd_count != '1)) begin
                        wr_meta_en = 1'b1;
                        wr_count   = rd_count + 1'b1;
                        ok_in      = 1'b1;
                        obj_out_in = obj_rd_wide[OBJ_PORT_W-1:0];
                     end
                  end

                  OP_RELEASE: begin
                     if (live_slot) begin
                        ok_in      = 1'b1;
                        wr_meta_en = 1'b1;
                        wr_count   = rd_count - 1'b1;
                        if (rd_count == COUNT_W'(1)) begin
                           // Last reference gone: retire the generation and push
                           // the slot onto the recycled list.
                           wr_gen       = rd_gen + 1'b1;
                           wr_body_en   = 1'b1;
                           wr_obj       = '0;
                           wr_tag       = '0;
                           wr_link      = head_ff;
                           head_in      = addr_ff;
                           if (live_ff != '0) begin
                              live_in = live_ff - 1'b1;
                           end
                           reclaimed_in = 1'b1;
                           obj_out_in   = obj_rd_wide[OBJ_PORT_W-1:0];
                           tag_out_in   = rd_tag;
                           run_free_in  = (rd_tag != '0);
                        end
                     end
                  end

                  default: begin
                  end
               endcase

               live_out_in  = live_wide[LIVE_PORT_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         head_ff       <= '0;
         fresh_ff      <= AW'(SLOTS - 1);
         live_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         head_ff       <= head_in;
         fresh_ff      <= fresh_in;
         live_ff       <= live_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff        <= op_in;
      obj_ff       <= obj_in;
      tag_ff       <= tag_in;
      hgen_ff      <= hgen_in;
      in_range_ff  <= in_range_in;
      got_ff       <= got_in;
      from_head_ff <= from_head_in;
      addr_ff      <= addr_in;
      ok_ff        <= ok_in;
      new_index_ff <= new_index_in;
      new_gen_ff   <= new_gen_in;
      obj_out_ff   <= obj_out_in;
      reclaimed_ff <= reclaimed_in;
      run_free_ff  <= run_free_in;
      tag_out_ff   <= tag_out_in;
      live_out_ff  <= live_out_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.ok             = ok_ff;
   assign rsp_chan.new_index      = new_index_ff;
   assign rsp_chan.new_generation = new_gen_ff;
   assign rsp_chan.object_out     = obj_out_ff;
   assign rsp_chan.reclaimed      = reclaimed_ff;
   assign rsp_chan.run_free       = run_free_ff;
   assign rsp_chan.free_tag_out   = tag_out_ff;
   assign rsp_chan.live_count     = live_out_ff;

endmodule

`default_nettype wire

// File: rtl/ght_slot_mem.sv
`default_nettype none

// Slot storage: a metadata memory (generation and count) and a body memory
// (object, free tag and recycled-list link), sharing one read and one write address.
module ght_slot_mem import ght_pkg::*; #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int GW    = 32,
   parameter int OW    = 48
) (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   input  logic               wr_meta_en,
   input  logic               wr_body_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [GW-1:0]      wr_gen,
   input  logic [COUNT_W-1:0] wr_count,
   input  logic [OW-1:0]      wr_obj,
   input  logic [TAG_W-1:0]   wr_tag,
   input  logic [AW-1:0]      wr_link,
   output logic [GW-1:0]      rd_gen,
   output logic [COUNT_W-1:0] rd_count,
   output logic [OW-1:0]      rd_obj,
   output logic [TAG_W-1:0]   rd_tag,
   output logic [AW-1:0]      rd_link
);

   localparam int META_W = GW + COUNT_W;
   localparam int BODY_W = OW + TAG_W + AW;

   logic [META_W-1:0] meta_mem [DEPTH];
   logic [BODY_W-1:0] body_mem [DEPTH];

   logic [META_W-1:0] meta_rd_ff;
   logic [BODY_W-1:0] body_rd_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         meta_rd_ff <= meta_mem[rd_addr];
         body_rd_ff <= body_mem[rd_addr];
      end
      if (wr_meta_en) begin
         meta_mem[wr_addr] <= {wr_gen, wr_count};
      end
      if (wr_body_en) begin
         body_mem[wr_addr] <= {wr_obj, wr_tag, wr_link};
      end
   end

   assign {rd_gen, rd_count}        = meta_rd_ff;
   assign {rd_obj, rd_tag, rd_link} = body_rd_ff;

endmodule

`default_nettype wire

// File: rtl/ght_checker.sv
`default_nettype none

module ght_checker import ght_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   ok,
   input  logic [IDX_PORT_W-1:0]  new_index,
   input  logic [HGEN_W-1:0]      new_generation,
   input  logic [OBJ_PORT_W-1:0]  object_out,
   input  logic                   reclaimed,
   input  logic                   run_free,
   input  logic [TAG_W-1:0]       free_tag_out,
   input  logic [LIVE_PORT_W-1:0] live_count
);

   // One request in flight at a time: ready drops after every transaction.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one still in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(live_count) && $stable(ok)
                                  && $stable(object_out))
      else $error("stalled response changed");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !ok |-> new_index == '0 && new_generation == '0 &&
                           object_out == '0 && !reclaimed && free_tag_out == '0)
      else $error("failed response carries data");

   a_run_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && run_free |-> ok && reclaimed && free_tag_out != '0 && new_index == '0)
      else $error("free notice without a reclaim");

endmodule

bind generational_handle_table ght_checker u_ght_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .ok             (rsp_chan.ok),
   .new_index      (rsp_chan.new_index),
   .new_generation (rsp_chan.new_generation),
   .object_out     (rsp_chan.object_out),
   .reclaimed      (rsp_chan.reclaimed),
   .run_free       (rsp_chan.run_free),
   .free_tag_out   (rsp_chan.free_tag_out),
   .live_count     (rsp_chan.live_count)
);

`default_nettype wire
